[rtl/qtcs_pkg.sv]
// Package for the query term coverage scorer: item types, queue entry,
// back-end state encoding, ASCII helpers and default sizes.
// No dependencies; every other file of the block but qtcs_ram uses it.
`timescale 1ns / 1ps

package qtcs_pkg;

  localparam int unsigned MAX_TERMS_DEF      = 16;
  localparam int unsigned MAX_TERM_CHARS_DEF = 8;
  localparam int unsigned CHARS_W            = 64;
  localparam int unsigned QUEUE_DEPTH        = 4;
  localparam int unsigned COUNT_W            = 5;
  localparam int unsigned SCORE_W            = 17;
  localparam int unsigned FRAC_W             = 16;

  localparam logic CMD_QUERY = 1'b0;
  localparam logic CMD_DOC   = 1'b1;

  localparam logic [7:0] ASCII_0     = 8'h30;
  localparam logic [7:0] ASCII_9     = 8'h39;
  localparam logic [7:0] ASCII_UP_A  = 8'h41;
  localparam logic [7:0] ASCII_UP_Z  = 8'h5a;
  localparam logic [7:0] ASCII_LO_A  = 8'h61;
  localparam logic [7:0] ASCII_LO_Z  = 8'h7a;
  localparam logic [7:0] ASCII_UNDER = 8'h5f;
  localparam logic [7:0] CASE_OFFSET = 8'h20;

  typedef struct packed {
    logic       command;
    logic [7:0] text_byte;
    logic       last;
  } in_item_t;

  typedef struct packed {
    logic [COUNT_W-1:0] hit_count;
    logic [COUNT_W-1:0] term_count;
    logic [SCORE_W-1:0] score_q16;
    logic               passed;
    logic               query_error;
  } out_item_t;

  typedef struct packed {
    logic               new_query;
    logic               tok_valid;
    logic               tok_query;
    logic               tok_overlong;
    logic               doc_end;
    logic [CHARS_W-1:0] chars;
  } entry_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_TOKEN,
    S_READ,
    S_CMP,
    S_MISS,
    S_FINISH,
    S_DIV,
    S_OUT
  } back_state_e;

  function automatic logic is_token_char(input logic [7:0] c);
    return (c inside {[ASCII_0:ASCII_9], [ASCII_UP_A:ASCII_UP_Z],
                      [ASCII_LO_A:ASCII_LO_Z], ASCII_UNDER});
  endfunction

  function automatic logic [7:0] to_lower(input logic [7:0] c);
    return (c inside {[ASCII_UP_A:ASCII_UP_Z]}) ? c + CASE_OFFSET : c;
  endfunction

endpackage

[rtl/qtcs_if.sv]
// Valid/ready channel interfaces for the input and result items.
// Depends on qtcs_pkg for the payload types.
`timescale 1ns / 1ps

interface qtcs_in_if;
  logic               valid;
  logic               ready;
  qtcs_pkg::in_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface qtcs_out_if;
  logic                valid;
  logic                ready;
  qtcs_pkg::out_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

[rtl/query_term_coverage_scorer_core.sv]
// Top level of the query term coverage scorer: threshold register, front end,
// entry queue and back end. Depends on qtcs_pkg, qtcs_if, qtcs_front,
// qtcs_fifo and qtcs_back.
//
// Text enters on in_i, one byte per item, with command (query or document)
// and last. Each finished document gives one result item on out_o: hit
// count, term count, Q16 coverage score, pass flag and query error flag.
// The threshold is to be written through cfg_we_i and cfg_wdata_i only
// while idle; the user is bound by this, the block does not enforce it.
// The front end takes one byte per cycle as long as the four-entry queue
// has room. The back end searches the term store RAM one entry at a time
// for each queued token, reading and comparing each stored term, with a
// miss step when no stored term matches. A document end adds the
// restoring divider, one quotient bit per cycle (skipped when no term is
// stored), and then loads the result register.
// A stalled receiver holds the result in the output register; the back end
// then waits at its next result and the queue fills until in_i.ready drops.
// Reset empties the queue, clears the term count, flags and threshold; the
// term store needs no clearing, since only entries below the count are read.
`timescale 1ns / 1ps

module query_term_coverage_scorer_core #(
  parameter int unsigned MAX_TERMS      = qtcs_pkg::MAX_TERMS_DEF,
  parameter int unsigned MAX_TERM_CHARS = qtcs_pkg::MAX_TERM_CHARS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  qtcs_in_if.sink                      in_i,
  qtcs_out_if.source                   out_o,
  input  logic                         cfg_we_i,
  input  logic [qtcs_pkg::SCORE_W-1:0] cfg_wdata_i
);

  logic [qtcs_pkg::SCORE_W-1:0] threshold_q;
  logic                         push, full, pop, empty;
  qtcs_pkg::entry_t             push_data, pop_data;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      threshold_q <= '0;
    end else if (cfg_we_i) begin
      threshold_q <= cfg_wdata_i;
    end
  end

  qtcs_front #(
    .MAX_TERM_CHARS (MAX_TERM_CHARS)
  ) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_i),
    .push_o  (push),
    .entry_o (push_data),
    .full_i  (full)
  );

  qtcs_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .pop_i       (pop),
    .pop_data_o  (pop_data),
    .empty_o     (empty)
  );

  qtcs_back #(
    .MAX_TERMS      (MAX_TERMS),
    .MAX_TERM_CHARS (MAX_TERM_CHARS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (empty),
    .entry_i     (pop_data),
    .pop_o       (pop),
    .threshold_i (threshold_q),
    .out_o       (out_o)
  );

endmodule

[rtl/qtcs_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`timescale 1ns / 1ps

module qtcs_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/qtcs_fifo.sv]
// Short queue of token entries between the front and back ends.
// Depends on qtcs_pkg for the entry type and depth.
`timescale 1ns / 1ps

module qtcs_fifo (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  qtcs_pkg::entry_t push_data_i,
  output logic             full_o,
  input  logic             pop_i,
  output qtcs_pkg::entry_t pop_data_o,
  output logic             empty_o
);

  localparam int unsigned DEPTH = qtcs_pkg::QUEUE_DEPTH;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned NW    = $clog2(DEPTH + 1);

  qtcs_pkg::entry_t store_q [DEPTH];
  logic [AW-1:0]    wptr_q, wptr_d;
  logic [AW-1:0]    rptr_q, rptr_d;
  logic [NW-1:0]    num_q, num_d;
  logic             do_push, do_pop;

  assign full_o     = (num_q == NW'(DEPTH));
  assign empty_o    = (num_q == '0);
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && !empty_o;
  assign pop_data_o = store_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    num_d  = num_q;
    if (do_push) begin
      wptr_d = (wptr_q == AW'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (do_pop) begin
      rptr_d = (rptr_q == AW'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      num_d = num_q + 1'b1;
    end else if (do_pop && !do_push) begin
      num_d = num_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      num_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      num_q  <= num_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      store_q[wptr_q] <= push_data_i;
    end
  end

endmodule

[rtl/qtcs_front.sv]
// Front end: accepts text items, builds lower-cased tokens and queues
// token, new-query and document-end entries. Depends on qtcs_pkg, qtcs_if.
`timescale 1ns / 1ps

module qtcs_front #(
  parameter int unsigned MAX_TERM_CHARS = qtcs_pkg::MAX_TERM_CHARS_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  qtcs_in_if.sink          in_i,
  output logic             push_o,
  output qtcs_pkg::entry_t entry_o,
  input  logic             full_i
);

  localparam int unsigned TW      = 8 * MAX_TERM_CHARS;
  localparam int unsigned LW      = $clog2(MAX_TERM_CHARS + 2);
  localparam int unsigned CHARS_W = qtcs_pkg::CHARS_W;

  logic [TW-1:0] tok_q, tok_d;
  logic [LW-1:0] len_q, len_d;
  logic          open_q, open_d;

  logic          accept, is_tc, restart, finish;
  logic [7:0]    lc;
  logic [TW-1:0] base_chars, app_chars, cand_chars;
  logic [LW-1:0] base_len, app_len, cand_len;

  assign in_i.ready = !full_i;
  assign accept     = in_i.valid && !full_i;
  assign is_tc      = qtcs_pkg::is_token_char(in_i.payload.text_byte);
  assign lc         = qtcs_pkg::to_lower(in_i.payload.text_byte);
  assign finish     = !is_tc || in_i.payload.last;
  assign restart    = (in_i.payload.command == qtcs_pkg::CMD_QUERY) ? !open_q : open_q;

  always_comb begin
    base_chars = restart ? '0 : tok_q;
    base_len   = restart ? '0 : len_q;
    app_chars  = base_chars;
    for (int b = 0; b < int'(MAX_TERM_CHARS); b++) begin
      if (base_len == LW'(b)) begin
        app_chars[8*b +: 8] = lc;
      end
    end
    app_len    = (base_len > LW'(MAX_TERM_CHARS)) ? base_len : base_len + 1'b1;
    cand_chars = is_tc ? app_chars : base_chars;
    cand_len   = is_tc ? app_len : base_len;
  end

  always_comb begin
    entry_o = '0;
    open_d  = open_q;
    tok_d   = tok_q;
    len_d   = len_q;
    if (in_i.payload.command == qtcs_pkg::CMD_QUERY) begin
      entry_o.new_query    = !open_q;
      entry_o.tok_valid    = finish && (cand_len >= LW'(2));
      entry_o.tok_query    = 1'b1;
      entry_o.tok_overlong = (cand_len > LW'(MAX_TERM_CHARS));
      entry_o.chars        = CHARS_W'(cand_chars);
      open_d               = !in_i.payload.last;
    end else begin
      entry_o.doc_end = in_i.payload.last;
      if (open_q) begin
        entry_o.tok_valid    = (len_q >= LW'(2));
        entry_o.tok_query    = 1'b1;
        entry_o.tok_overlong = (len_q > LW'(MAX_TERM_CHARS));
        entry_o.chars        = CHARS_W'(tok_q);
      end else begin
        entry_o.tok_valid = finish && (cand_len >= LW'(2)) &&
                            (cand_len <= LW'(MAX_TERM_CHARS));
        entry_o.chars     = CHARS_W'(cand_chars);
      end
      open_d = 1'b0;
    end
    tok_d = finish ? '0 : app_chars;
    len_d = finish ? '0 : app_len;
    if (!accept) begin
      open_d = open_q;
      tok_d  = tok_q;
      len_d  = len_q;
    end
  end

  assign push_o = accept && (entry_o.new_query || entry_o.tok_valid || entry_o.doc_end);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q  <= '0;
      len_q  <= '0;
      open_q <= 1'b0;
    end else begin
      tok_q  <= tok_d;
      len_q  <= len_d;
      open_q <= open_d;
    end
  end

endmodule

[rtl/qtcs_back.sv]
// Back end: searches and fills the term store, marks hits, divides for the
// score and holds the result register. Depends on qtcs_pkg, qtcs_if, qtcs_ram.
`timescale 1ns / 1ps

module qtcs_back #(
  parameter int unsigned MAX_TERMS      = qtcs_pkg::MAX_TERMS_DEF,
  parameter int unsigned MAX_TERM_CHARS = qtcs_pkg::MAX_TERM_CHARS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          empty_i,
  input  qtcs_pkg::entry_t              entry_i,
  output logic                          pop_o,
  input  logic [qtcs_pkg::SCORE_W-1:0]  threshold_i,
  qtcs_out_if.source                    out_o
);

  localparam int unsigned TW      = 8 * MAX_TERM_CHARS;
  localparam int unsigned IW      = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
  localparam int unsigned CW      = $clog2(MAX_TERMS + 1);
  localparam int unsigned FRAC_W  = qtcs_pkg::FRAC_W;
  localparam int unsigned NW      = CW + FRAC_W;
  localparam int unsigned DW      = $clog2(NW + 1);
  localparam int unsigned SCORE_W = qtcs_pkg::SCORE_W;
  localparam int unsigned COUNT_W = qtcs_pkg::COUNT_W;

  qtcs_pkg::back_state_e state_q, state_d;
  qtcs_pkg::entry_t      ent_q, ent_d;
  logic [CW-1:0]         stored_q, stored_d;
  logic                  err_q, err_d;
  logic [MAX_TERMS-1:0]  marks_q, marks_d;
  logic [CW-1:0]         hits_q, hits_d;
  logic [IW-1:0]         idx_q, idx_d;
  logic [NW-1:0]         num_q, num_d;
  logic [CW:0]           rem_q, rem_d;
  logic [NW-1:0]         quo_q, quo_d;
  logic [DW-1:0]         dcnt_q, dcnt_d;
  logic                  out_valid_q, out_valid_d;
  qtcs_pkg::out_item_t   out_q, out_d;

  logic                  ram_we;
  logic [TW-1:0]         ram_rdata;
  logic [CW:0]           shifted;
  logic [SCORE_W-1:0]    score;

  qtcs_ram #(
    .WIDTH (TW),
    .DEPTH (MAX_TERMS)
  ) u_term_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (stored_q[IW-1:0]),
    .wdata_i (ent_q.chars[TW-1:0]),
    .raddr_i (idx_q),
    .rdata_o (ram_rdata)
  );

  assign shifted     = {rem_q[CW-1:0], num_q[NW-1]};
  assign score       = quo_q[SCORE_W-1:0];
  assign out_o.valid   = out_valid_q;
  assign out_o.payload = out_q;

  always_comb begin
    state_d     = state_q;
    ent_d       = ent_q;
    stored_d    = stored_q;
    err_d       = err_q;
    marks_d     = marks_q;
    hits_d      = hits_q;
    idx_d       = idx_q;
    num_d       = num_q;
    rem_d       = rem_q;
    quo_d       = quo_q;
    dcnt_d      = dcnt_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_o.ready;
    pop_o       = 1'b0;
    ram_we      = 1'b0;

    case (state_q)
      qtcs_pkg::S_IDLE: begin
        if (!empty_i) begin
          pop_o   = 1'b1;
          ent_d   = entry_i;
          state_d = qtcs_pkg::S_TOKEN;
          if (entry_i.new_query) begin
            stored_d = '0;
            err_d    = 1'b0;
            marks_d  = '0;
            hits_d   = '0;
          end
        end
      end
      qtcs_pkg::S_TOKEN: begin
        idx_d = '0;
        if (!ent_q.tok_valid) begin
          state_d = qtcs_pkg::S_FINISH;
        end else if (ent_q.tok_query && ent_q.tok_overlong) begin
          err_d   = 1'b1;
          state_d = qtcs_pkg::S_FINISH;
        end else if (stored_q == '0) begin
          state_d = qtcs_pkg::S_MISS;
        end else begin
          state_d = qtcs_pkg::S_READ;
        end
      end
      qtcs_pkg::S_READ: begin
        state_d = qtcs_pkg::S_CMP;
      end
      qtcs_pkg::S_CMP: begin
        if (ram_rdata == ent_q.chars[TW-1:0]) begin
          if (!ent_q.tok_query && !marks_q[idx_q]) begin
            marks_d[idx_q] = 1'b1;
            hits_d         = hits_q + 1'b1;
          end
          state_d = qtcs_pkg::S_FINISH;
        end else if (CW'(idx_q) + 1'b1 == stored_q) begin
          state_d = qtcs_pkg::S_MISS;
        end else begin
          idx_d   = idx_q + 1'b1;
          state_d = qtcs_pkg::S_READ;
        end
      end
      qtcs_pkg::S_MISS: begin
        if (ent_q.tok_query) begin
          if (stored_q < CW'(MAX_TERMS)) begin
            ram_we   = 1'b1;
            stored_d = stored_q + 1'b1;
          end else begin
            err_d = 1'b1;
          end
        end
        state_d = qtcs_pkg::S_FINISH;
      end
      qtcs_pkg::S_FINISH: begin
        if (!ent_q.doc_end) begin
          state_d = qtcs_pkg::S_IDLE;
        end else if (stored_q == '0) begin
          quo_d   = '0;
          state_d = qtcs_pkg::S_OUT;
        end else begin
          num_d   = {hits_q, FRAC_W'(0)};
          rem_d   = '0;
          quo_d   = '0;
          dcnt_d  = DW'(NW);
          state_d = qtcs_pkg::S_DIV;
        end
      end
      qtcs_pkg::S_DIV: begin
        num_d = {num_q[NW-2:0], 1'b0};
        if (shifted >= {1'b0, stored_q}) begin
          rem_d = shifted - {1'b0, stored_q};
          quo_d = {quo_q[NW-2:0], 1'b1};
        end else begin
          rem_d = shifted;
          quo_d = {quo_q[NW-2:0], 1'b0};
        end
        dcnt_d = dcnt_q - 1'b1;
        if (dcnt_q == DW'(1)) begin
          state_d = qtcs_pkg::S_OUT;
        end
      end
      qtcs_pkg::S_OUT: begin
        if (!out_valid_q || out_o.ready) begin
          out_valid_d       = 1'b1;
          out_d.hit_count   = COUNT_W'(hits_q);
          out_d.term_count  = COUNT_W'(stored_q);
          out_d.score_q16   = score;
          out_d.passed      = (stored_q != '0) && (score >= threshold_i);
          out_d.query_error = err_q;
          marks_d           = '0;
          hits_d            = '0;
          state_d           = qtcs_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = qtcs_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= qtcs_pkg::S_IDLE;
      stored_q    <= '0;
      err_q       <= 1'b0;
      marks_q     <= '0;
      hits_q      <= '0;
      idx_q       <= '0;
      dcnt_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      stored_q    <= stored_d;
      err_q       <= err_d;
      marks_q     <= marks_d;
      hits_q      <= hits_d;
      idx_q       <= idx_d;
      dcnt_q      <= dcnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
    num_q <= num_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
    out_q <= out_d;
  end

endmodule

[test/query_term_coverage_scorer_core_tb.sv]
// Self-checking testbench for query_term_coverage_scorer_core: directed and random query and
// document text with random idling and back-pressure, checked against an in-bench scorer model.
// Depends on qtcs_pkg, qtcs_if and the RTL of the block.
`timescale 1ns / 1ps

module query_term_coverage_scorer_core_tb;

  localparam int unsigned TERMS         = qtcs_pkg::MAX_TERMS_DEF;
  localparam int unsigned WORD_CHARS    = qtcs_pkg::MAX_TERM_CHARS_DEF;
  localparam int unsigned ITEM_TARGET   = 1350;
  localparam int unsigned PHASES        = 7;
  localparam int unsigned PHASE_DOCS    = 1;
  localparam int unsigned SETTLE_CYCLES = 300;
  localparam int unsigned HOLD_CYCLES   = 400;
  localparam int unsigned IDLE_LIMIT    = 4000;
  localparam int unsigned MAX_REPORTS   = 10;
  localparam logic [qtcs_pkg::SCORE_W-1:0] SCORE_ONE = 17'h10000;

  logic                         clk;
  logic                         rst_n;
  logic                         cfg_we;
  logic [qtcs_pkg::SCORE_W-1:0] cfg_wdata;

  qtcs_in_if  in_if ();
  qtcs_out_if out_if ();

  query_term_coverage_scorer_core u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_i        (in_if),
    .out_o       (out_if),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata)
  );

  initial clk = 1'b0;
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Scorer model state.
  logic [63:0]                  kw_store [TERMS];
  int unsigned                  kw_count      = 0;
  logic [TERMS-1:0]             hit_mask      = '0;
  logic [63:0]                  tok_chars     = '0;
  int unsigned                  tok_len       = 0;
  bit                           query_active  = 1'b0;
  bit                           query_err     = 1'b0;
  logic [qtcs_pkg::SCORE_W-1:0] threshold_q   = '0;

  qtcs_pkg::out_item_t pending_scores [$];
  qtcs_pkg::out_item_t want_score;
  logic [7:0]          text_buf [$];
  logic [95:0]         vocab_chars [32];
  int unsigned         vocab_len [32];
  int unsigned         vocab_size;

  int unsigned items_sent     = 0;
  int unsigned docs_predicted = 0;
  int unsigned docs_scored    = 0;
  int unsigned docs_flagged   = 0;
  int unsigned docs_passed    = 0;
  int unsigned cfg_writes     = 0;
  int unsigned fail_count     = 0;
  int unsigned idle_cycles    = 0;
  int unsigned tx_idle_pct    = 0;
  int unsigned rx_idle_pct    = 0;
  int unsigned rx_hold_req    = 0;
  int unsigned rx_wait        = 0;

  function automatic bit is_letter(input logic [7:0] c);
    return (c >= qtcs_pkg::ASCII_UP_A && c <= qtcs_pkg::ASCII_UP_Z) ||
           (c >= qtcs_pkg::ASCII_LO_A && c <= qtcs_pkg::ASCII_LO_Z);
  endfunction

  function automatic bit word_char(input logic [7:0] c);
    return is_letter(c) || (c >= qtcs_pkg::ASCII_0 && c <= qtcs_pkg::ASCII_9) ||
           c == qtcs_pkg::ASCII_UNDER;
  endfunction

  function automatic logic [7:0] fold_case(input logic [7:0] c);
    if (c >= qtcs_pkg::ASCII_UP_A && c <= qtcs_pkg::ASCII_UP_Z) begin
      return c + qtcs_pkg::CASE_OFFSET;
    end
    return c;
  endfunction

  function int kw_index(input logic [63:0] w);
    for (int i = 0; i < kw_count; i++) begin
      if (kw_store[i] == w) begin
        return i;
      end
    end
    return -1;
  endfunction

  function void append_token_char(input logic [7:0] c);
    if (tok_len < WORD_CHARS) begin
      tok_chars[8*tok_len +: 8] = fold_case(c);
    end
    if (tok_len <= WORD_CHARS) begin
      tok_len++;
    end
  endfunction

  function void end_query_token();
    if (tok_len >= 2) begin
      if (tok_len > WORD_CHARS) begin
        query_err = 1'b1;
      end else if (kw_index(tok_chars) < 0) begin
        if (kw_count < TERMS) begin
          kw_store[kw_count] = tok_chars;
          kw_count++;
        end else begin
          query_err = 1'b1;
        end
      end
    end
    tok_chars = '0;
    tok_len   = 0;
  endfunction

  function void end_doc_token();
    int k;
    if (tok_len >= 2 && tok_len <= WORD_CHARS) begin
      k = kw_index(tok_chars);
      if (k >= 0) begin
        hit_mask[k] = 1'b1;
      end
    end
    tok_chars = '0;
    tok_len   = 0;
  endfunction

  function void predict_coverage(input qtcs_pkg::in_item_t it);
    qtcs_pkg::out_item_t res;
    int unsigned         hits;
    logic [32:0]         score;
    if (it.command == qtcs_pkg::CMD_QUERY) begin
      if (!query_active) begin
        kw_count     = 0;
        query_err    = 1'b0;
        hit_mask     = '0;
        tok_chars    = '0;
        tok_len      = 0;
        query_active = 1'b1;
      end
      if (word_char(it.text_byte)) begin
        append_token_char(it.text_byte);
      end else begin
        end_query_token();
      end
      if (it.last) begin
        end_query_token();
        query_active = 1'b0;
      end
      return;
    end
    // A document byte closes an open query before it is taken as text.
    if (query_active) begin
      end_query_token();
      query_active = 1'b0;
      hit_mask     = '0;
    end
    if (word_char(it.text_byte)) begin
      append_token_char(it.text_byte);
    end else begin
      end_doc_token();
    end
    if (!it.last) begin
      return;
    end
    end_doc_token();
    hits  = $countones(hit_mask);
    score = '0;
    if (kw_count != 0) begin
      score = (33'(hits) << qtcs_pkg::FRAC_W) / 33'(kw_count);
      if (score > 33'(SCORE_ONE)) begin
        score = 33'(SCORE_ONE);
      end
    end
    res.hit_count   = hits[qtcs_pkg::COUNT_W-1:0];
    res.term_count  = kw_count[qtcs_pkg::COUNT_W-1:0];
    res.score_q16   = score[qtcs_pkg::SCORE_W-1:0];
    res.passed      = (kw_count != 0) && (score >= 33'(threshold_q));
    res.query_error = query_err;
    pending_scores = {pending_scores, res};
    hit_mask = '0;
    docs_predicted++;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 80) begin
      return $urandom_range(1, 3);
    end else if (r < 97) begin
      return $urandom_range(4, 12);
    end
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [7:0] rand_word_char();
    int unsigned r;
    r = $urandom_range(0, 62);
    if (r < 26) begin
      return qtcs_pkg::ASCII_LO_A + 8'(r);
    end else if (r < 52) begin
      return qtcs_pkg::ASCII_UP_A + 8'(r - 26);
    end else if (r < 62) begin
      return qtcs_pkg::ASCII_0 + 8'(r - 52);
    end
    return qtcs_pkg::ASCII_UNDER;
  endfunction

  function automatic logic [7:0] rand_gap_char();
    logic [7:0] c;
    do begin
      c = 8'($urandom_range(0, 255));
    end while (word_char(c));
    return c;
  endfunction

  function void add_gap();
    repeat ($urandom_range(1, 2)) text_buf = {text_buf, rand_gap_char()};
  endfunction

  function void strip_gap();
    while (text_buf.size() != 0 && !word_char(text_buf[text_buf.size()-1])) begin
      void'(text_buf.pop_back());
    end
  endfunction

  // A stretched word gets extra characters, so a known prefix turns into a longer, sometimes overlong token.
  function void add_word(input int unsigned idx, input bit stretch);
    logic [7:0] c;
    for (int i = 0; i < vocab_len[idx]; i++) begin
      c = vocab_chars[idx][8*i +: 8];
      if (is_letter(c) && $urandom_range(0, 3) == 0) begin
        c = c ^ qtcs_pkg::CASE_OFFSET;
      end
      text_buf = {text_buf, c};
    end
    if (stretch) begin
      repeat ($urandom_range(1, 2)) text_buf = {text_buf, rand_word_char()};
    end
  endfunction

  function void add_noise_word();
    repeat ($urandom_range(1, 10)) text_buf = {text_buf, rand_word_char()};
  endfunction

  function void build_vocab(input int unsigned n, input bit plain);
    int unsigned r;
    vocab_size = n;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (plain || r < 80) begin
        vocab_len[i] = $urandom_range(2, 8);
      end else if (r < 88) begin
        vocab_len[i] = 1;
      end else begin
        vocab_len[i] = $urandom_range(9, 12);
      end
      vocab_chars[i] = '0;
      for (int j = 0; j < vocab_len[i]; j++) begin
        vocab_chars[i][8*j +: 8] = rand_word_char();
      end
    end
  endfunction

  task automatic push_byte(input logic cmd, input logic [7:0] b, input logic fin);
    qtcs_pkg::in_item_t it;
    int unsigned        gap;
    it.command   = cmd;
    it.text_byte = b;
    it.last      = fin;
    in_if.valid   <= 1'b1;
    in_if.payload <= it;
    do @(posedge clk); while (!in_if.ready);
    predict_coverage(it);
    items_sent++;
    if (tx_idle_pct != 0 && $urandom_range(0, 99) < tx_idle_pct) begin
      gap = pick_gap();
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_text(input logic cmd, input bit fin);
    int n;
    n = text_buf.size();
    for (int i = 0; i < n; i++) begin
      push_byte(cmd, text_buf[i], fin && i == n - 1);
    end
    text_buf.delete();
  endtask

  task automatic send_string(input logic cmd, input string s, input bit fin);
    for (int i = 0; i < s.len(); i++) begin
      push_byte(cmd, s[i], fin && i == s.len() - 1);
    end
  endtask

  task automatic wait_results_done();
    in_if.valid <= 1'b0;
    while (pending_scores.size() != 0) @(posedge clk);
  endtask

  task automatic set_threshold(input logic [qtcs_pkg::SCORE_W-1:0] value);
    wait_results_done();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we      <= 1'b0;
    threshold_q = value;
    cfg_writes++;
  endtask

  // One query followed by a few documents. A crowded query holds more distinct terms
  // than the store takes.
  task automatic run_session();
    bit          crowded;
    int unsigned nq;
    int unsigned nw;
    int unsigned r;
    crowded = ($urandom_range(0, 99) < 15);
    build_vocab(crowded ? $urandom_range(17, 24) : $urandom_range(2, 12), crowded);
    nq = crowded ? vocab_size + $urandom_range(0, 4) : $urandom_range(0, 8);
    for (int i = 0; i < nq; i++) begin
      add_word((crowded && i < vocab_size) ? i : $urandom_range(0, vocab_size - 1), 1'b0);
      add_gap();
    end
    if ($urandom_range(0, 1) == 0) begin
      strip_gap();
    end
    if (text_buf.size() == 0) begin
      add_gap();
    end
    send_text(qtcs_pkg::CMD_QUERY, $urandom_range(0, 99) >= 15);
    repeat ($urandom_range(1, 5)) begin
      if (crowded && $urandom_range(0, 2) == 0) begin
        for (int i = 0; i < TERMS; i++) begin
          add_word(i, 1'b0);
          add_gap();
        end
      end else begin
        nw = crowded ? $urandom_range(0, 24) : $urandom_range(0, 8);
        repeat (nw) begin
          r = $urandom_range(0, 99);
          if (r < 75) begin
            add_word($urandom_range(0, vocab_size - 1), r < 5);
          end else begin
            add_noise_word();
          end
          add_gap();
        end
      end
      if ($urandom_range(0, 1) == 0) begin
        strip_gap();
      end
      if (text_buf.size() == 0) begin
        add_gap();
      end
      send_text(qtcs_pkg::CMD_DOC, $urandom_range(0, 99) >= 5);
    end
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(3, 10)) begin
        push_byte(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                  $urandom_range(0, 3) == 0);
      end
    end
  endtask

  task automatic test_empty_document();
    push_byte(qtcs_pkg::CMD_DOC, 8'h00, 1'b1);
  endtask

  task automatic test_character_classes();
    set_threshold(SCORE_ONE);
    send_string(qtcs_pkg::CMD_QUERY, "Az", 1'b0);
    push_byte(qtcs_pkg::CMD_QUERY, 8'h80, 1'b0);
    send_string(qtcs_pkg::CMD_QUERY, "09_`q", 1'b0);
    push_byte(qtcs_pkg::CMD_QUERY, 8'h7b, 1'b1);
    send_string(qtcs_pkg::CMD_DOC, "@AZ", 1'b0);
    push_byte(qtcs_pkg::CMD_DOC, 8'hff, 1'b0);
    send_string(qtcs_pkg::CMD_DOC, "09_", 1'b1);
  endtask

  task automatic test_overlong_and_early_document();
    send_string(qtcs_pkg::CMD_QUERY, "aaaaaaaaa Bb", 1'b0);
    send_string(qtcs_pkg::CMD_DOC, "bB", 1'b1);
  endtask

  task automatic test_query_aborts_document();
    send_string(qtcs_pkg::CMD_DOC, "bb", 1'b0);
    send_string(qtcs_pkg::CMD_QUERY, "xy", 1'b1);
    send_string(qtcs_pkg::CMD_DOC, "XY", 1'b1);
  endtask

  task automatic test_output_backpressure();
    set_threshold(17'd32768);
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    rx_hold_req = HOLD_CYCLES;
    repeat (2) run_session();
    wait_results_done();
  endtask

  task automatic test_random_traffic();
    logic [qtcs_pkg::SCORE_W-1:0] levels [PHASES];
    int unsigned                  docs_start;
    levels = '{SCORE_ONE, 17'd0, 17'd21845, 17'd21846, 17'd32768, 17'd1, 17'd0};
    levels[PHASES-1] = 17'($urandom_range(0, 65536));
    for (int p = 0; p < PHASES; p++) begin
      set_threshold(levels[p]);
      tx_idle_pct = (p % 3 == 0) ? 0 : 30;
      rx_idle_pct = (p % 2 == 0) ? 30 : 0;
      docs_start  = docs_predicted;
      while (items_sent < ITEM_TARGET * (p + 1) / PHASES ||
             docs_predicted - docs_start < PHASE_DOCS) begin
        run_session();
      end
    end
  endtask

  initial begin
    in_if.valid   = 1'b0;
    in_if.payload = '0;
    cfg_we        = 1'b0;
    cfg_wdata     = '0;
    rst_n         = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_empty_document();
    test_character_classes();
    test_overlong_and_early_document();
    test_query_aborts_document();
    test_output_backpressure();
    test_random_traffic();
    wait_results_done();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (pending_scores.size() != 0) begin
      fail_count += pending_scores.size();
      $display("%0d expected results never arrived", pending_scores.size());
    end
    $display("Covered %0d text items and %0d scored documents (%0d passing, %0d with a query error)",
             items_sent, docs_scored, docs_passed, docs_flagged);
    $display("under %0d threshold settings, with idling, a long output stall and aborted documents",
             cfg_writes);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rx_hold_req != 0) begin
        rx_wait     = rx_hold_req;
        rx_hold_req = 0;
      end else if (rx_wait == 0 && rx_idle_pct != 0 && $urandom_range(0, 99) < rx_idle_pct) begin
        rx_wait = pick_gap();
      end
      if (rx_wait != 0) begin
        out_if.ready <= 1'b0;
        rx_wait--;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready) begin
      docs_scored++;
      if (pending_scores.size() == 0) begin
        fail_count++;
        if (fail_count <= MAX_REPORTS) begin
          $display("Unexpected result: hits %0d terms %0d score %0d passed %0d error %0d",
                   out_if.payload.hit_count, out_if.payload.term_count,
                   out_if.payload.score_q16, out_if.payload.passed,
                   out_if.payload.query_error);
        end
      end else begin
        want_score = pending_scores.pop_front();
        if (want_score.passed) begin
          docs_passed++;
        end
        if (want_score.query_error) begin
          docs_flagged++;
        end
        if (out_if.payload.hit_count !== want_score.hit_count ||
            out_if.payload.term_count !== want_score.term_count ||
            out_if.payload.score_q16 !== want_score.score_q16 ||
            out_if.payload.passed !== want_score.passed ||
            out_if.payload.query_error !== want_score.query_error) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS) begin
            $display("Result %0d mismatch: expected hits %0d terms %0d score %0d passed %0d error %0d",
                     docs_scored, want_score.hit_count, want_score.term_count,
                     want_score.score_q16, want_score.passed, want_score.query_error);
            $display("  got hits %0d terms %0d score %0d passed %0d error %0d",
                     out_if.payload.hit_count, out_if.payload.term_count,
                     out_if.payload.score_q16, out_if.payload.passed,
                     out_if.payload.query_error);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("No item moved on either channel for %0d cycles", IDLE_LIMIT);
        $display("Verification failed");
        $finish;
      end
    end
  end

endmodule
